FILE: rtl/core/first_fit_arena_allocator_defines.svh
// Assertion macros shared by the first-fit arena allocator RTL.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef FIRST_FIT_ARENA_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FFA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ffa_pkg.sv
// Shared types and fixed constants of the first-fit arena allocator.
// No dependencies.
package ffa_pkg;

	localparam int FIELD_W     = 16;
	localparam int STATUS_W    = 3;
	localparam int ADDR_RES_W  = 13;
	localparam int SPLIT_SLACK = 8;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_BAD_SIZE    = 3'd1,
		ST_NO_MEM      = 3'd2,
		ST_NULL_FREE   = 3'd3,
		ST_DOUBLE_FREE = 3'd4,
		ST_NOT_START   = 3'd5
	} status_t;

endpackage

FILE: rtl/core/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 4100
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [$clog2(DEPTH)-1:0]            wr_addr,
	input  logic [WIDTH-1:0]                    wr_data,
	input  logic [$clog2(DEPTH)-1:0]            rd_addr,
	output logic [WIDTH-1:0]                    rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one word, read one word a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/first_fit_arena_allocator.sv
// First-fit arena allocator over an implicit header list.
// Depends on ffa_pkg, ffa_ram and first_fit_arena_allocator_defines.svh.
//
// Usage:
//  Request channel in_valid/in_stall carries op, size and address. op selects
//  allocate (size = payload bytes) or free (address = payload offset).
//  Result channel out_valid/out_stall carries status and address_res; each
//  request gives exactly one result. One request is worked on at a time and
//  in_stall stays high from acceptance until the sequencer is idle again.
//  Timing: the header RAM has one read and one write port, and the walk reads
//  one header per cycle. Allocate walks the headers up to the first fit and
//  writes a split header when the block is split. Free checks its header,
//  then walks the list from the start and merges adjacent free blocks. Bad
//  size, null free and out-of-range frees finish without a walk. Worst case is
//  about ARENA_BYTES/(HEADER_BYTES+1) headers per request. Reset: the header
//  RAM is swept one entry per cycle over ARENA_BYTES + HEADER_BYTES entries
//  (4100 at defaults), leaving one free block; in_stall is high during the sweep.
//  Output stall: the result sits in an output register; the next request is
//  accepted and worked on, and its result waits until the register frees.
module first_fit_arena_allocator #(
	parameter int ARENA_BYTES  = 4096,
	parameter int HEADER_BYTES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [ffa_pkg::FIELD_W-1:0]     size,
	input  logic [ffa_pkg::FIELD_W-1:0]     address,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ffa_pkg::STATUS_W-1:0]    status,
	output logic [ffa_pkg::ADDR_RES_W-1:0]  address_res
);

	localparam int TOTAL = ARENA_BYTES + HEADER_BYTES;
	localparam int AW    = $clog2(TOTAL);
	localparam int SW    = $clog2(ARENA_BYTES + 1);
	localparam int HW    = SW + 2;
	localparam int FW    = ffa_pkg::FIELD_W + 1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_WALK,
		S_A_WR,
		S_F_RD,
		S_F_CHK,
		S_M_SEED,
		S_M_WALK,
		S_M_WP,
		S_FINISH
	} state_t;

	state_t                              state_q;
	logic [AW-1:0]                       clr_q;
	logic [AW-1:0]                       p_q;
	logic [AW:0]                         n_q;
	logic [SW-1:0]                       size_q;
	logic                                cur_used_q;
	logic [SW-1:0]                       cur_size_q;
	ffa_pkg::status_t                    res_status_q;
	logic [ffa_pkg::ADDR_RES_W-1:0]      res_addr_q;
	logic                                out_valid_q;
	ffa_pkg::status_t                    status_q;
	logic [ffa_pkg::ADDR_RES_W-1:0]      address_res_q;

	// RAM port signals
	logic                                wr_en;
	logic [AW-1:0]                       wr_addr;
	logic [HW-1:0]                       wr_data;
	logic [AW-1:0]                       rd_addr;
	logic [HW-1:0]                       rd_data;

	// Decoded header and shared adder
	logic                                hd_start;
	logic                                hd_used;
	logic [SW-1:0]                       hd_size;
	logic                                fit;
	logic [SW-1:0]                       rem;
	logic                                split;
	logic                                do_merge;
	logic [AW-1:0]                       add_a;
	logic [SW-1:0]                       add_b;
	logic [AW:0]                         sum;
	logic                                sum_in;
	logic [AW:0]                         payload;
	logic [FW-1:0]                       free_hdr;
	logic                                res_fail;

	ffa_ram #(
		.WIDTH (HW),
		.DEPTH (TOTAL)
	) u_hdr_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Split the header word read last cycle
	assign hd_start = rd_data[SW+1];
	assign hd_used  = rd_data[SW];
	assign hd_size  = rd_data[SW-1:0];
	assign fit      = hd_start && !hd_used && (hd_size >= size_q);
	assign rem      = hd_size - size_q;
	assign split    = rem > SW'(HEADER_BYTES + ffa_pkg::SPLIT_SLACK);
	assign do_merge = !cur_used_q && hd_start && !hd_used;
	assign payload  = {1'b0, p_q} + (AW+1)'(HEADER_BYTES);
	assign free_hdr = {1'b0, address} - FW'(HEADER_BYTES);

	// Select adder operands: next header, split point or merged size
	always_comb begin
		add_a = p_q;
		add_b = hd_size;
		unique case (state_q)
			S_A_WALK: begin
				add_a = p_q;
				add_b = fit ? size_q : hd_size;
			end
			S_M_WALK: begin
				add_a = do_merge ? AW'(cur_size_q) : n_q[AW-1:0];
				add_b = hd_size;
			end
			S_M_WP: begin
				add_a = p_q;
				add_b = cur_size_q;
			end
			default: begin
				add_a = p_q;
				add_b = hd_size;
			end
		endcase
	end

	assign sum    = {1'b0, add_a} + (AW+1)'(HEADER_BYTES) + (AW+1)'(add_b);
	assign sum_in = sum < (AW+1)'(TOTAL);

	// Drive the header RAM from the sequencer state
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = p_q;
		wr_data = '0;
		rd_addr = p_q;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = (clr_q == '0) ? {1'b1, 1'b0, SW'(ARENA_BYTES)} : '0;
			end
			S_IDLE: begin
				rd_addr = '0;
			end
			S_A_WALK: begin
				if (fit) begin
					wr_en = 1'b1;
					if (split && sum_in) begin
						wr_addr = sum[AW-1:0];
						wr_data = {1'b1, 1'b0, SW'(rem - SW'(HEADER_BYTES))};
					end else begin
						wr_data = {1'b1, 1'b1, hd_size};
					end
				end else begin
					rd_addr = sum[AW-1:0];
				end
			end
			S_A_WR: begin
				wr_en   = 1'b1;
				wr_data = {1'b1, 1'b1, size_q};
			end
			S_F_CHK: begin
				wr_en   = hd_start && hd_used;
				wr_data = {1'b1, 1'b0, hd_size};
			end
			S_M_SEED: begin
				rd_addr = '0;
			end
			S_M_WALK: begin
				if (do_merge) begin
					wr_en   = 1'b1;
					wr_addr = n_q[AW-1:0];
					wr_data = '0;
				end else begin
					rd_addr = sum[AW-1:0];
				end
			end
			S_M_WP: begin
				wr_en   = 1'b1;
				wr_data = {1'b1, 1'b0, cur_size_q};
				rd_addr = sum[AW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Sequencer: sweep, walk headers, merge, hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			p_q           <= '0;
			n_q           <= '0;
			size_q        <= '0;
			cur_used_q    <= 1'b0;
			cur_size_q    <= '0;
			res_status_q  <= ffa_pkg::ST_OK;
			res_addr_q    <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ffa_pkg::ST_OK;
			address_res_q <= '0;
		end else begin
			// Drop the result once taken, unless the finish step replaces it
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TOTAL - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						res_addr_q   <= '0;
						res_status_q <= ffa_pkg::ST_OK;
						if (op == ffa_pkg::OP_ALLOC) begin
							if (size == '0 || size > ffa_pkg::FIELD_W'(ARENA_BYTES)) begin
								res_status_q <= ffa_pkg::ST_BAD_SIZE;
								state_q      <= S_FINISH;
							end else begin
								size_q  <= size[SW-1:0];
								p_q     <= '0;
								state_q <= S_A_WALK;
							end
						end else begin
							if (address == '0) begin
								res_status_q <= ffa_pkg::ST_NULL_FREE;
								state_q      <= S_FINISH;
							end else if (address < ffa_pkg::FIELD_W'(HEADER_BYTES) ||
							             free_hdr >= FW'(TOTAL)) begin
								res_status_q <= ffa_pkg::ST_NOT_START;
								state_q      <= S_FINISH;
							end else begin
								p_q     <= free_hdr[AW-1:0];
								state_q <= S_F_RD;
							end
						end
					end
				end
				S_A_WALK: begin
					if (!hd_start) begin
						res_status_q <= ffa_pkg::ST_NO_MEM;
						state_q      <= S_FINISH;
					end else if (fit) begin
						res_addr_q <= ffa_pkg::ADDR_RES_W'(payload);
						state_q    <= (split && sum_in) ? S_A_WR : S_FINISH;
					end else if (sum_in) begin
						p_q <= sum[AW-1:0];
					end else begin
						res_status_q <= ffa_pkg::ST_NO_MEM;
						state_q      <= S_FINISH;
					end
				end
				S_A_WR: begin
					state_q <= S_FINISH;
				end
				S_F_RD: begin
					state_q <= S_F_CHK;
				end
				S_F_CHK: begin
					if (!hd_start) begin
						res_status_q <= ffa_pkg::ST_NOT_START;
						state_q      <= S_FINISH;
					end else if (!hd_used) begin
						res_status_q <= ffa_pkg::ST_DOUBLE_FREE;
						state_q      <= S_FINISH;
					end else begin
						state_q <= S_M_SEED;
					end
				end
				S_M_SEED: begin
					// Start the merge walk with no mergeable predecessor
					n_q        <= '0;
					cur_used_q <= 1'b1;
					state_q    <= S_M_WALK;
				end
				S_M_WALK: begin
					if (do_merge) begin
						cur_size_q <= sum[SW-1:0];
						state_q    <= S_M_WP;
					end else if (!hd_start) begin
						state_q <= S_FINISH;
					end else begin
						p_q        <= n_q[AW-1:0];
						cur_used_q <= hd_used;
						cur_size_q <= hd_size;
						n_q        <= sum;
						if (!sum_in) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_M_WP: begin
					n_q     <= sum;
					state_q <= sum_in ? S_M_WALK : S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						status_q      <= res_status_q;
						address_res_q <= res_addr_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign address_res = address_res_q;
	assign res_fail    = out_valid && (status != ffa_pkg::ST_OK);

	`include "first_fit_arena_allocator_defines.svh"

	`FFA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "busy not raised")
	`FFA_ASSERT_IMPL(a_fail_zero_addr, res_fail, address_res == '0, "failed with address")
	`FFA_ASSERT_IMPL(a_idle_no_write, state_q == S_IDLE, !wr_en, "write while idle")
	`FFA_ASSERT_IMPL(a_res_finish, $rose(out_valid), $past(state_q == S_FINISH), "stray result")

endmodule
